// ----- sv/closed_polyline_smoother_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the closed polyline smoother
// Shared property forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CLOSED_POLYLINE_SMOOTHER_TOP_ASSERT_SVH
`define CLOSED_POLYLINE_SMOOTHER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/cps_pkg.sv -----
// ----------------------------------------------------------------------------
// cps_pkg
// Widths, constants and divider interface types of the polyline smoother.
// ----------------------------------------------------------------------------
package cps_pkg;

    localparam int DEF_MAX_POINTS = 64;
    localparam int DEF_MAX_SMOOTH = 16;

    localparam int COORD_W    = 10;
    localparam int POINT_W    = 2 * COORD_W;
    localparam int SMOOTH_W   = 5;
    localparam int ENDW_W     = 9;
    localparam int WGT_W      = 17;
    localparam int TOT_W      = 22;
    localparam int PROD_W     = WGT_W + COORD_W;
    localparam int ACC_W      = 32;
    localparam int RECIP_W    = 16;
    localparam int FIN_W      = ACC_W + RECIP_W;
    localparam int RES_W      = 18;
    localparam int IDX_W      = 6;
    localparam int DIV_NUM_W  = 33;
    localparam int DIV_DEN_W  = 22;
    localparam int DIV_CNT_W  = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 48;

    localparam logic [SMOOTH_W-1:0]  SMOOTH_RESET     = 5'd8;
    localparam logic [ENDW_W-1:0]    END_WEIGHT_RESET = 9'd0;
    localparam logic [ENDW_W-1:0]    END_WEIGHT_MAX   = 9'd256;
    localparam logic [WGT_W-1:0]     WGT_ONE          = 17'h1_0000;
    localparam logic [DIV_NUM_W-1:0] RECIP_NUM        = 33'h1_0000_0000;
    localparam logic [RECIP_W-1:0]   RECIP_MAX        = 16'hFFFF;
    localparam logic [FIN_W-1:0]     ROUND_HALF       = 48'h80_0000;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS        = 6'd33;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_WEIGHT  = 1'd1;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] dividend;
        logic [DIV_DEN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ----- sv/closed_polyline_smoother_top.sv -----
// Weight setup follows the last point's transfer: one division per weight, then one
// for the reciprocal (S = clamped smooth_size, none when S is zero); each smoothed
// point then takes 2 * S + 1 tap reads, a drain, two multiply steps and one load.
// Points load one per cycle in the load state, entered again after the last result.
// Reset (rst_n low, asynchronous) empties the contour and restores smooth_size 8
// and end_weight 0; the point memory itself is not cleared.
// ----------------------------------------------------------------------------
// closed_polyline_smoother_top
// Circular weighted moving average over one closed contour held in a memory.
// ----------------------------------------------------------------------------
`include "closed_polyline_smoother_top_assert.svh"

module closed_polyline_smoother_top
#(
    parameter int MAX_POINTS = cps_pkg::DEF_MAX_POINTS,
    parameter int MAX_SMOOTH = cps_pkg::DEF_MAX_SMOOTH
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    // Input points. tdata: point_x [9:0], point_y [19:10], zeros above.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [cps_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  logic                             s_axis_tlast,   // last_point
    // Smoothed points. tdata: smooth_x [17:0], smooth_y [35:18],
    // point_index [41:36], zeros above.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [cps_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic                             m_axis_tlast,   // last_result
    output logic                             m_axis_tuser,   // overflow
    // Configuration writes.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cps_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import cps_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int JW = $clog2(MAX_SMOOTH + 1);

    // Sequencer states.
    localparam logic [3:0] ST_LOAD   = 4'd0;
    localparam logic [3:0] ST_WSTART = 4'd1;
    localparam logic [3:0] ST_WWAIT  = 4'd2;
    localparam logic [3:0] ST_RSTART = 4'd3;
    localparam logic [3:0] ST_RWAIT  = 4'd4;
    localparam logic [3:0] ST_TAPS   = 4'd5;
    localparam logic [3:0] ST_DRAIN  = 4'd6;
    localparam logic [3:0] ST_MULX   = 4'd7;
    localparam logic [3:0] ST_MULY   = 4'd8;
    localparam logic [3:0] ST_EMIT   = 4'd9;

    // Configuration registers.
    logic [SMOOTH_W-1:0] smooth_size_reg;
    logic [ENDW_W-1:0]   end_weight_reg;

    // Contour bookkeeping.
    logic [3:0]          state_reg;
    logic [3:0]          state_next;
    logic [CW-1:0]       count_reg;
    logic                overflow_seen_reg;
    logic [AW-1:0]       last_idx_reg;
    logic                ovf_reg;

    // Weight setup.
    logic [JW-1:0]       s_reg;
    logic [ENDW_W-1:0]   e_reg;
    logic [JW-1:0]       j_reg;
    logic [TOT_W-1:0]    total_reg;
    logic [RECIP_W-1:0]  recip_reg;
    logic [WGT_W-1:0]    w_reg [1:MAX_SMOOTH];

    // Tap walk and multiply-accumulate pipeline.
    logic [AW-1:0]       i_reg;
    logic [AW-1:0]       left_reg;
    logic [AW-1:0]       right_reg;
    logic                tap_first_reg;
    logic                side_left_reg;
    logic                p1_valid_reg;
    logic                p2_valid_reg;
    logic                p1_first_reg;
    logic                p2_first_reg;
    logic [WGT_W-1:0]    wgt_p1_reg;
    logic [POINT_W-1:0]  rd_data_reg;
    logic [PROD_W-1:0]   prod_x_reg;
    logic [PROD_W-1:0]   prod_y_reg;
    logic [ACC_W-1:0]    acc_x_reg;
    logic [ACC_W-1:0]    acc_y_reg;
    logic [FIN_W-1:0]    fin_prod_reg;
    logic [RES_W-1:0]    res_x_reg;

    // Output register.
    logic                out_valid_reg;
    logic [RES_W-1:0]    out_x_reg;
    logic [RES_W-1:0]    out_y_reg;
    logic [IDX_W-1:0]    out_idx_reg;
    logic                out_last_reg;
    logic                out_ovf_reg;

    // The point memory: one write port used while loading, one read port for taps.
    logic [POINT_W-1:0]  point_mem [MAX_POINTS];

    logic                in_xfer;
    logic                has_room;
    logic                mem_wr;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       left_dec;
    logic [AW-1:0]       right_inc;
    logic [WGT_W-1:0]    wsel;
    logic                issue;
    logic                last_issue;
    logic                out_free;
    logic                out_load;
    logic [JW-1:0]       s_clamped;
    logic [ENDW_W-1:0]   e_clamped;
    logic [TOT_W-1:0]    numer;
    logic [RES_W-1:0]    res_fin;
    div_req_t            div_req;
    div_rsp_t            div_rsp;

    cps_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Configuration is always accepted; only writing it while idle is up to the user.
    assign cfg_ready = 1'b1;

    // Points are taken only while loading, so memory writes never meet tap reads.
    assign s_axis_tready = (state_reg == ST_LOAD);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign has_room      = (count_reg < CW'(MAX_POINTS));
    assign mem_wr        = in_xfer && has_room;

    assign s_clamped = (smooth_size_reg > SMOOTH_W'(MAX_SMOOTH)) ?
                       JW'(MAX_SMOOTH) : JW'(smooth_size_reg);
    assign e_clamped = (end_weight_reg > END_WEIGHT_MAX) ? END_WEIGHT_MAX : end_weight_reg;

    // Weight j numerator: 65536 * (S - j) + 256 * E * j, divided by S in the divider.
    assign numer = (TOT_W'(s_reg - j_reg) << 16) + ((TOT_W'(e_reg) * TOT_W'(j_reg)) << 8);

    always_comb
    begin
        div_req.start    = (state_reg == ST_WSTART) || (state_reg == ST_RSTART);
        div_req.dividend = (state_reg == ST_WSTART) ? DIV_NUM_W'(numer) : RECIP_NUM;
        div_req.divisor  = (state_reg == ST_WSTART) ? DIV_DEN_W'(s_reg) : total_reg;
    end

    // Neighbor pointers step outward from the center one place per tap, wrapping
    // around the contour, so a short contour revisits its points.
    assign left_dec  = (left_reg == '0) ? last_idx_reg : left_reg - 1'b1;
    assign right_inc = (right_reg == last_idx_reg) ? '0 : right_reg + 1'b1;
    assign issue     = (state_reg == ST_TAPS);

    always_comb
    begin
        if (tap_first_reg)
        begin
            rd_addr    = i_reg;
            wsel       = WGT_ONE;
            last_issue = (s_reg == '0);
        end
        else if (side_left_reg)
        begin
            rd_addr    = left_dec;
            wsel       = w_reg[j_reg];
            last_issue = 1'b0;
        end
        else
        begin
            rd_addr    = right_inc;
            wsel       = w_reg[j_reg];
            last_issue = (j_reg == s_reg);
        end
    end

    assign out_free = !out_valid_reg || m_axis_tready;
    assign out_load = (state_reg == ST_EMIT) && out_free;

    // Round half up from Q.16 times Q0.16 down to Q.8; without smoothing the
    // accumulator holds the coordinate in Q.16 and is simply cut to Q.8.
    function automatic logic [RES_W-1:0] round_q8(input logic s_zero,
                                                  input logic [FIN_W-1:0] prod,
                                                  input logic [ACC_W-1:0] acc);
        logic [FIN_W-1:0] sum;
        sum = prod + ROUND_HALF;
        if (s_zero)
        begin
            round_q8 = acc[RES_W+7:8];
        end
        else
        begin
            round_q8 = sum[RES_W+23:24];
        end
    endfunction

    assign res_fin = round_q8(s_reg == '0, fin_prod_reg, acc_y_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_xfer && s_axis_tlast)
                begin
                    state_next = (s_clamped == '0) ? ST_TAPS : ST_WSTART;
                end
            end
            ST_WSTART:
            begin
                state_next = ST_WWAIT;
            end
            ST_WWAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = (j_reg == s_reg) ? ST_RSTART : ST_WSTART;
                end
            end
            ST_RSTART:
            begin
                state_next = ST_RWAIT;
            end
            ST_RWAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_TAPS;
                end
            end
            ST_TAPS:
            begin
                if (last_issue)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // The last product is being added at this edge.
                if (p2_valid_reg && !p1_valid_reg)
                begin
                    state_next = ST_MULX;
                end
            end
            ST_MULX:
            begin
                state_next = ST_MULY;
            end
            ST_MULY:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = (i_reg == last_idx_reg) ? ST_LOAD : ST_TAPS;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_LOAD;
            smooth_size_reg   <= SMOOTH_RESET;
            end_weight_reg    <= END_WEIGHT_RESET;
            count_reg         <= '0;
            overflow_seen_reg <= 1'b0;
            tap_first_reg     <= 1'b1;
            side_left_reg     <= 1'b1;
            p1_valid_reg      <= 1'b0;
            p2_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SMOOTH_SIZE: smooth_size_reg <= cfg_data[SMOOTH_W-1:0];
                    CFG_END_WEIGHT:  end_weight_reg  <= cfg_data;
                    default:         ;
                endcase
            end

            if (in_xfer)
            begin
                if (s_axis_tlast)
                begin
                    // The contour is closed; its size and flag move to the walk.
                    count_reg         <= '0;
                    overflow_seen_reg <= 1'b0;
                end
                else if (has_room)
                begin
                    count_reg <= count_reg + 1'b1;
                end
                else
                begin
                    overflow_seen_reg <= 1'b1;
                end
            end

            if (issue)
            begin
                tap_first_reg <= 1'b0;
                if (tap_first_reg)
                begin
                    side_left_reg <= 1'b1;
                end
                else
                begin
                    side_left_reg <= !side_left_reg;
                end
            end
            else if (state_reg == ST_EMIT)
            begin
                tap_first_reg <= 1'b1;
            end

            p1_valid_reg <= issue;
            p2_valid_reg <= p1_valid_reg;

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        if (in_xfer && s_axis_tlast)
        begin
            s_reg        <= s_clamped;
            e_reg        <= e_clamped;
            j_reg        <= JW'(1);
            i_reg        <= '0;
            total_reg    <= TOT_W'(WGT_ONE);
            ovf_reg      <= overflow_seen_reg || !has_room;
            last_idx_reg <= has_room ? count_reg[AW-1:0] : AW'(MAX_POINTS - 1);
        end

        if ((state_reg == ST_WWAIT) && div_rsp.done)
        begin
            w_reg[j_reg] <= div_rsp.quotient[WGT_W-1:0];
            total_reg    <= total_reg + (TOT_W'(div_rsp.quotient[WGT_W-1:0]) << 1);
            if (j_reg != s_reg)
            begin
                j_reg <= j_reg + 1'b1;
            end
        end

        if ((state_reg == ST_RWAIT) && div_rsp.done)
        begin
            recip_reg <= (div_rsp.quotient[DIV_NUM_W-1:RECIP_W] != '0) ?
                         RECIP_MAX : div_rsp.quotient[RECIP_W-1:0];
        end

        if (issue)
        begin
            wgt_p1_reg   <= wsel;
            p1_first_reg <= tap_first_reg;
            if (tap_first_reg)
            begin
                left_reg  <= i_reg;
                right_reg <= i_reg;
                j_reg     <= JW'(1);
            end
            else if (side_left_reg)
            begin
                left_reg <= rd_addr;
            end
            else
            begin
                right_reg <= rd_addr;
                j_reg     <= j_reg + 1'b1;
            end
        end

        prod_x_reg   <= wgt_p1_reg * rd_data_reg[COORD_W-1:0];
        prod_y_reg   <= wgt_p1_reg * rd_data_reg[POINT_W-1:COORD_W];
        p2_first_reg <= p1_first_reg;

        if (p2_valid_reg)
        begin
            // The center tap starts a fresh sum.
            if (p2_first_reg)
            begin
                acc_x_reg <= ACC_W'(prod_x_reg);
                acc_y_reg <= ACC_W'(prod_y_reg);
            end
            else
            begin
                acc_x_reg <= acc_x_reg + ACC_W'(prod_x_reg);
                acc_y_reg <= acc_y_reg + ACC_W'(prod_y_reg);
            end
        end

        // One shared multiplier scales both sums by the reciprocal in turn.
        if (state_reg == ST_MULX)
        begin
            fin_prod_reg <= acc_x_reg * recip_reg;
        end
        if (state_reg == ST_MULY)
        begin
            res_x_reg    <= round_q8(s_reg == '0, fin_prod_reg, acc_x_reg);
            fin_prod_reg <= acc_y_reg * recip_reg;
        end

        if (out_load)
        begin
            out_x_reg    <= res_x_reg;
            out_y_reg    <= res_fin;
            out_idx_reg  <= IDX_W'(i_reg);
            out_last_reg <= (i_reg == last_idx_reg);
            out_ovf_reg  <= ovf_reg;
            if (i_reg != last_idx_reg)
            begin
                i_reg <= i_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            point_mem[count_reg[AW-1:0]] <= {s_axis_tdata[POINT_W-1:COORD_W],
                                             s_axis_tdata[COORD_W-1:0]};
        end
        rd_data_reg <= point_mem[rd_addr];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - 2 * RES_W - IDX_W){1'b0}},
                            out_idx_reg, out_y_reg, out_x_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_ovf_reg;

    `CPS_ASSERT_SAME(a_wr_no_reads, mem_wr, !p1_valid_reg && !p2_valid_reg, "memory write during tap reads")
    `CPS_ASSERT_SAME(a_out_no_overwrite, out_load, !out_valid_reg || m_axis_tready, "result overwritten")
    `CPS_ASSERT_SAME(a_index_in_range, issue, i_reg <= last_idx_reg, "point index beyond contour")
    `CPS_ASSERT_SAME(a_div_done_wait, div_rsp.done, (state_reg == ST_WWAIT) || (state_reg == ST_RWAIT), "divider done outside wait")
    `CPS_ASSERT_NEXT(a_last_empties, in_xfer && s_axis_tlast, count_reg == '0, "count not cleared after last point")

endmodule

// ----- sv/cps_div.sv -----
// ----------------------------------------------------------------------------
// cps_div
// Restoring divider, one quotient bit per cycle, shared by weight setup and the reciprocal.
// ----------------------------------------------------------------------------
module cps_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  cps_pkg::div_req_t req,
    output cps_pkg::div_rsp_t rsp
);
    import cps_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] dvs_reg;
    logic [DIV_NUM_W-1:0] quo_reg;

    logic [DIV_DEN_W:0]   trial;
    logic                 fits;

    // Dividend bits shift out of the top of quo_reg while quotient bits enter below.
    assign trial = {rem_reg, quo_reg[DIV_NUM_W-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_STEPS;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_NUM_W-2:0], fits};
            if (fits)
            begin
                rem_reg <= DIV_DEN_W'(trial - {1'b0, dvs_reg});
            end
            else
            begin
                rem_reg <= trial[DIV_DEN_W-1:0];
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule
